/* design/dcm_pkg.sv */
package dcm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int SCALE_W  = 24;
    localparam int CODE_W   = 16;
    localparam int DEPTH_W  = 40;
    localparam int INV_W    = 41;
    localparam int T_W      = 17;
    localparam int COLOR_W  = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 41;

    // Width of the rounding products of the color stage (255 * 65536 + 32768 < 2^24).
    localparam int PROD_W = 25;

    localparam logic [T_W-1:0]     Q16_ONE     = 17'h1_0000;
    localparam logic [PROD_W-1:0]  ROUND_HALF  = 25'd32768;
    localparam logic [PROD_W-1:0]  RED_GAIN    = 25'd255;
    localparam logic [PROD_W-1:0]  GREEN_GAIN  = 25'd190;
    localparam logic [COLOR_W-1:0] GREEN_BASE  = 8'd35;

    localparam logic [COLOR_W-1:0] BG_RED   = 8'd18;
    localparam logic [COLOR_W-1:0] BG_GREEN = 8'd20;
    localparam logic [COLOR_W-1:0] BG_BLUE  = 8'd22;

    localparam logic [SCALE_W-1:0] RST_DEPTH_SCALE   = 24'd16777;
    localparam logic [CODE_W-1:0]  RST_INVALID_CODE  = 16'd0;
    localparam logic [DEPTH_W-1:0] RST_MIN_DEPTH     = 40'd0;
    localparam logic [DEPTH_W-1:0] RST_MAX_DEPTH     = 40'd83886080;
    localparam logic [INV_W-1:0]   RST_INVERSE_RANGE = 41'd13107;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH_SCALE   = 3'd0,
        REG_INVALID_CODE  = 3'd1,
        REG_MIN_DEPTH     = 3'd2,
        REG_MAX_DEPTH     = 3'd3,
        REG_INVERSE_RANGE = 3'd4
    } t_cfg_idx;

    // Control that travels with each pipeline stage.
    typedef struct packed {
        logic vld;
        logic show;
    } t_ctl;

endpackage

/* design/depth_to_color_map.sv */
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_ready   i_depth_sample[15:0]
// output    out        o_valid / i_ready   o_red[7:0], o_green[7:0], o_blue[7:0]
// config    in         i_cfg_we            i_cfg_idx[2:0], i_cfg_data[40:0]
//
// One item per clock while the output is not stalled.
// The pipeline has six register stages: scale, window check, split
// multiply, partial product sum, saturate and fold, color rounding.
// Reset is synchronous and active low; it clears the stage valid bits and
// loads the default registers. No clearing pass is needed.
// A stall on the output freezes every stage at once, so nothing is lost or repeated.
module depth_to_color_map (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [dcm_pkg::SAMPLE_W-1:0]   i_depth_sample,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [dcm_pkg::COLOR_W-1:0]    o_red,
    output logic [dcm_pkg::COLOR_W-1:0]    o_green,
    output logic [dcm_pkg::COLOR_W-1:0]    o_blue,
    input  logic                           i_cfg_we,
    input  logic [dcm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [dcm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import dcm_pkg::*;

    logic [SCALE_W-1:0] r_depth_scale;
    logic [CODE_W-1:0]  r_invalid_code;
    logic [DEPTH_W-1:0] r_min_depth;
    logic [DEPTH_W-1:0] r_max_depth;
    logic [INV_W-1:0]   r_inverse_range;

    logic               w_en;
    t_ctl               w_ctl_rng;
    logic [DEPTH_W-1:0] w_diff;
    t_ctl               w_ctl_frac;
    logic [T_W-1:0]     w_t;
    logic [T_W-1:0]     w_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_scale   <= RST_DEPTH_SCALE;
            r_invalid_code  <= RST_INVALID_CODE;
            r_min_depth     <= RST_MIN_DEPTH;
            r_max_depth     <= RST_MAX_DEPTH;
            r_inverse_range <= RST_INVERSE_RANGE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                REG_DEPTH_SCALE:   r_depth_scale   <= i_cfg_data[SCALE_W-1:0];
                REG_INVALID_CODE:  r_invalid_code  <= i_cfg_data[CODE_W-1:0];
                REG_MIN_DEPTH:     r_min_depth     <= i_cfg_data[DEPTH_W-1:0];
                REG_MAX_DEPTH:     r_max_depth     <= i_cfg_data[DEPTH_W-1:0];
                REG_INVERSE_RANGE: r_inverse_range <= i_cfg_data[INV_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless a finished item is held at the output.
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    dcm_range u_range (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_vld          (i_valid),
        .i_sample       (i_depth_sample),
        .i_depth_scale  (r_depth_scale),
        .i_invalid_code (r_invalid_code),
        .i_min_depth    (r_min_depth),
        .i_max_depth    (r_max_depth),
        .o_ctl          (w_ctl_rng),
        .o_diff         (w_diff)
    );

    dcm_frac u_frac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_ctl       (w_ctl_rng),
        .i_diff      (w_diff),
        .i_inv_range (r_inverse_range),
        .o_ctl       (w_ctl_frac),
        .o_t         (w_t),
        .o_m         (w_m)
    );

    dcm_color u_color (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (w_ctl_frac),
        .i_t     (w_t),
        .i_m     (w_m),
        .o_vld   (o_valid),
        .o_red   (o_red),
        .o_green (o_green),
        .o_blue  (o_blue)
    );

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("input taken while the output item is stalled");

    a_reset_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("output valid right after reset");

    a_green_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_green < GREEN_BASE)) |->
            (o_red == BG_RED && o_green == BG_GREEN && o_blue == BG_BLUE))
        else $error("green below its floor on a shown pixel");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n && i_cfg_we && (i_cfg_idx == REG_INVALID_CODE)) |->
            (r_invalid_code == $past(i_cfg_data[CODE_W-1:0])))
        else $error("invalid code register not updated by a write");

endmodule

/* design/dcm_range.sv */
module dcm_range (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_vld,
    input  logic [dcm_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [dcm_pkg::SCALE_W-1:0]  i_depth_scale,
    input  logic [dcm_pkg::CODE_W-1:0]   i_invalid_code,
    input  logic [dcm_pkg::DEPTH_W-1:0]  i_min_depth,
    input  logic [dcm_pkg::DEPTH_W-1:0]  i_max_depth,
    output dcm_pkg::t_ctl                o_ctl,
    output logic [dcm_pkg::DEPTH_W-1:0]  o_diff
);
    import dcm_pkg::*;

    t_ctl               r_ctl_a;
    logic [DEPTH_W-1:0] r_d;
    logic [DEPTH_W-1:0] n_d;
    t_ctl               r_ctl_b;
    logic [DEPTH_W-1:0] r_diff;
    logic               n_show;
    logic [DEPTH_W-1:0] n_diff;

    // First stage: raw count times meters per count, exact in 40 bits.
    assign n_d = DEPTH_W'(i_sample) * DEPTH_W'(i_depth_scale);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_a <= '0;
        end else if (i_en) begin
            r_ctl_a.vld  <= i_vld;
            r_ctl_a.show <= (i_sample != i_invalid_code);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    // Second stage: window check and offset from the lower bound.
    assign n_show = r_ctl_a.show && (r_d >= i_min_depth) && (r_d <= i_max_depth);
    assign n_diff = r_d - i_min_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_b <= '0;
        end else if (i_en) begin
            r_ctl_b.vld  <= r_ctl_a.vld;
            r_ctl_b.show <= n_show;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= n_diff;
        end
    end

    assign o_ctl  = r_ctl_b;
    assign o_diff = r_diff;

endmodule

/* design/dcm_frac.sv */
module dcm_frac (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  dcm_pkg::t_ctl               i_ctl,
    input  logic [dcm_pkg::DEPTH_W-1:0] i_diff,
    input  logic [dcm_pkg::INV_W-1:0]   i_inv_range,
    output dcm_pkg::t_ctl               o_ctl,
    output logic [dcm_pkg::T_W-1:0]     o_t,
    output logic [dcm_pkg::T_W-1:0]     o_m
);
    import dcm_pkg::*;

    localparam int A_LO_W = 20;
    localparam int A_HI_W = DEPTH_W - A_LO_W;
    localparam int B_LO_W = 21;
    localparam int B_HI_W = INV_W - B_LO_W;
    localparam int P10_W  = A_HI_W + B_LO_W;
    localparam int P01_W  = A_LO_W + B_HI_W;
    localparam int P00_W  = A_LO_W + B_LO_W;
    localparam int SUM_W  = 63;
    localparam int FRAC_SHIFT = 24;

    logic [A_HI_W-1:0] w_a1;
    logic [A_LO_W-1:0] w_a0;
    logic [B_HI_W-1:0] w_b1;
    logic [B_LO_W-1:0] w_b0;

    t_ctl             r_ctl_c;
    logic             r_hi_nz;
    logic [P10_W-1:0] r_p10;
    logic [P01_W-1:0] r_p01;
    logic [P00_W-1:0] r_p00;

    logic [SUM_W-1:0] n_sum;
    t_ctl             r_ctl_d;
    logic             r_over;
    logic [T_W-1:0]   r_mid;

    logic [T_W-1:0]   n_t;
    logic [T_W:0]     n_two_t;
    logic [T_W:0]     n_dist;
    logic [T_W-1:0]   n_m;
    t_ctl             r_ctl_e;
    logic [T_W-1:0]   r_t;
    logic [T_W-1:0]   r_m;

    assign w_a1 = i_diff[DEPTH_W-1:A_LO_W];
    assign w_a0 = i_diff[A_LO_W-1:0];
    assign w_b1 = i_inv_range[INV_W-1:B_LO_W];
    assign w_b0 = i_inv_range[B_LO_W-1:0];

    // Partial products. The high-by-high term lands at 2^41 or above, which
    // always saturates, so only whether it is nonzero matters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_c <= '0;
        end else if (i_en) begin
            r_ctl_c <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi_nz <= (w_a1 != '0) && (w_b1 != '0);
            r_p10   <= P10_W'(w_a1) * P10_W'(w_b0);
            r_p01   <= P01_W'(w_a0) * P01_W'(w_b1);
            r_p00   <= P00_W'(w_a0) * P00_W'(w_b0);
        end
    end

    assign n_sum = (SUM_W'(r_p10) << A_LO_W) + (SUM_W'(r_p01) << B_LO_W) + SUM_W'(r_p00);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_d <= '0;
        end else if (i_en) begin
            r_ctl_d <= r_ctl_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_over <= r_hi_nz || (|n_sum[SUM_W-1:FRAC_SHIFT+T_W]);
            r_mid  <= n_sum[FRAC_SHIFT+T_W-1:FRAC_SHIFT];
        end
    end

    // Saturate t at 1.0, then fold it into the mid-range weight m.
    always_comb begin
        n_t     = (r_over || (r_mid > Q16_ONE)) ? Q16_ONE : r_mid;
        n_two_t = {n_t, 1'b0};
        if (n_two_t >= {1'b0, Q16_ONE}) begin
            n_dist = n_two_t - {1'b0, Q16_ONE};
        end else begin
            n_dist = {1'b0, Q16_ONE} - n_two_t;
        end
        n_m = Q16_ONE - n_dist[T_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_e <= '0;
        end else if (i_en) begin
            r_ctl_e <= r_ctl_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t <= n_t;
            r_m <= n_m;
        end
    end

    assign o_ctl = r_ctl_e;
    assign o_t   = r_t;
    assign o_m   = r_m;

endmodule

/* design/dcm_color.sv */
module dcm_color (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  dcm_pkg::t_ctl               i_ctl,
    input  logic [dcm_pkg::T_W-1:0]     i_t,
    input  logic [dcm_pkg::T_W-1:0]     i_m,
    output logic                        o_vld,
    output logic [dcm_pkg::COLOR_W-1:0] o_red,
    output logic [dcm_pkg::COLOR_W-1:0] o_green,
    output logic [dcm_pkg::COLOR_W-1:0] o_blue
);
    import dcm_pkg::*;

    localparam int CH_LSB = 16;

    logic [PROD_W-1:0]  n_red_p;
    logic [PROD_W-1:0]  n_green_p;
    logic [PROD_W-1:0]  n_blue_p;
    logic [COLOR_W-1:0] n_red;
    logic [COLOR_W-1:0] n_green;
    logic [COLOR_W-1:0] n_blue;
    logic               r_vld;
    logic [COLOR_W-1:0] r_red;
    logic [COLOR_W-1:0] r_green;
    logic [COLOR_W-1:0] r_blue;

    // Round half up: add one half in Q16 and keep the integer bits.
    always_comb begin
        n_red_p   = PROD_W'(i_t) * RED_GAIN + ROUND_HALF;
        n_green_p = PROD_W'(i_m) * GREEN_GAIN + ROUND_HALF;
        n_blue_p  = PROD_W'(Q16_ONE - i_t) * RED_GAIN + ROUND_HALF;
        if (i_ctl.show) begin
            n_red   = n_red_p[CH_LSB+COLOR_W-1:CH_LSB];
            n_green = GREEN_BASE + n_green_p[CH_LSB+COLOR_W-1:CH_LSB];
            n_blue  = n_blue_p[CH_LSB+COLOR_W-1:CH_LSB];
        end else begin
            n_red   = BG_RED;
            n_green = BG_GREEN;
            n_blue  = BG_BLUE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_vld   = r_vld;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule
